// ===== hw/rtl/sacfs_pkg.sv =====
// types, codes and field widths of the fifo cache simulator
package sacfs_pkg;

  localparam int OP_W         = 2;
  localparam int ADDR_W       = 64;
  localparam int OUTCOME_W    = 2;
  localparam int TOTAL_W      = 32;
  localparam int SET_BITS_W   = 3;
  localparam int BLOCK_BITS_W = 6;
  localparam int WAYS_W       = 4;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 6;

  localparam logic [SET_BITS_W-1:0]   SET_BITS_RST   = 3'd0;
  localparam logic [BLOCK_BITS_W-1:0] BLOCK_BITS_RST = 6'd4;
  localparam logic [WAYS_W-1:0]       WAYS_RST       = 4'd1;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD   = 2'd0,
    OP_STORE  = 2'd1,
    OP_MODIFY = 2'd2
  } op_e;

  typedef enum logic [OUTCOME_W-1:0] {
    OUT_HIT   = 2'd0,
    OUT_FILL  = 2'd1,
    OUT_EVICT = 2'd2
  } outcome_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SET_BITS   = 2'd0,
    CFG_BLOCK_BITS = 2'd1,
    CFG_WAYS       = 2'd2
  } cfg_idx_e;

endpackage

// ===== hw/rtl/sacfs_intf.sv =====
// handshake channels for access, result and configuration beats
interface sacfs_in_if import sacfs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [ADDR_W-1:0] address;

  modport source (output valid, output op, output address, input ready);
  modport sink (input valid, input op, input address, output ready);
endinterface

interface sacfs_out_if import sacfs_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [OUTCOME_W-1:0] outcome;
  logic                 modify_hit;
  logic [TOTAL_W-1:0]   hit_total;
  logic [TOTAL_W-1:0]   miss_total;
  logic [TOTAL_W-1:0]   eviction_total;

  modport source (output valid, output outcome, output modify_hit, output hit_total,
                  output miss_total, output eviction_total, input ready);
  modport sink (input valid, input outcome, input modify_hit, input hit_total,
                input miss_total, input eviction_total, output ready);
endinterface

interface sacfs_cfg_if import sacfs_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/sacfs_ram.sv =====
// generic simple dual port ram with registered read
module sacfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/set_assoc_cache_fifo_sim.sv =====
// set associative cache simulator with fifo replacement, top level
// After reset the set state memory is cleared, one set a cycle, while no access is taken;
// configuration beats are taken at any time. An access is first taken and its block offset
// shifted off; next the set's fill count, fifo pointer and first tag are read and the address
// split into set and tag; then one way is compared per cycle, since the single tag comparator
// works through the ways one tag memory read at a time and stops at the first hit, at the ways
// in use or at the last filled way, the last compare held while the output register is full.
// The result is registered in the last compare cycle, with the tag and set state written back
// on a miss; the result then waits in the output register while the next access is taken.
module set_assoc_cache_fifo_sim import sacfs_pkg::*; #(
  parameter int MAX_SET_BITS = 6,
  parameter int MAX_WAYS     = 8,
  parameter int COUNT_WIDTH  = 32
) (
  input logic         clk_i,
  input logic         rst_ni,
  sacfs_cfg_if.sink   cfg_i,
  sacfs_in_if.sink    in_i,
  sacfs_out_if.source out_o
);

  localparam int SET_AW   = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int NUM_SETS = 2 ** SET_AW;
  localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int FILL_W   = $clog2(MAX_WAYS + 1);
  localparam int LINE_AW  = SET_AW + WAY_W;
  localparam int NUM_LINES = 2 ** LINE_AW;
  localparam int META_W   = FILL_W + WAY_W;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_META,
    S_CMP
  } state_e;

  state_e state_q;

  logic [SET_BITS_W-1:0]   set_bits_q;
  logic [BLOCK_BITS_W-1:0] block_bits_q;
  logic [WAYS_W-1:0]       ways_in_use_q;

  logic [SET_AW-1:0]      clr_q;
  logic [OP_W-1:0]        op_q;
  logic [ADDR_W-1:0]      addr_sh_q;
  logic [ADDR_W-1:0]      tag_q;
  logic [SET_AW-1:0]      set_q;
  logic [WAYS_W-1:0]      ways_q;
  logic [WAY_W-1:0]       way_q;
  logic [COUNT_WIDTH-1:0] hit_cnt_q, miss_cnt_q, evict_cnt_q;
  logic [COUNT_WIDTH-1:0] hit_cnt_d, miss_cnt_d, evict_cnt_d;

  logic                   out_valid_q;
  logic [OUTCOME_W-1:0]   outcome_q;
  logic                   modify_hit_q;
  logic [TOTAL_W-1:0]     hit_total_q, miss_total_q, evict_total_q;

  logic [SET_BITS_W-1:0]  sb;
  logic [WAYS_W-1:0]      ways_eff;
  logic [SET_AW-1:0]      set_idx;
  logic [FILL_W-1:0]      fill;
  logic [WAY_W-1:0]       oldest;
  logic [WAY_W-1:0]       victim;
  logic [WAY_W-1:0]       oldest_next;
  logic                   line_hit;
  logic                   more;
  logic                   is_fill;
  logic                   is_modify;
  logic                   out_free;
  logic                   commit;
  logic [1:0]             hit_inc;
  logic [COUNT_WIDTH:0]   hit_sum;
  outcome_e               outcome_d;

  logic                   meta_we, meta_re;
  logic [SET_AW-1:0]      meta_waddr, meta_raddr;
  logic [META_W-1:0]      meta_wdata, meta_rdata;
  logic                   tag_we, tag_re;
  logic [LINE_AW-1:0]     tag_waddr, tag_raddr;
  logic [ADDR_W-1:0]      tag_rdata;

  // configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_bits_q    <= SET_BITS_RST;
      block_bits_q  <= BLOCK_BITS_RST;
      ways_in_use_q <= WAYS_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_SET_BITS:   set_bits_q    <= cfg_i.data[SET_BITS_W-1:0];
        CFG_BLOCK_BITS: block_bits_q  <= cfg_i.data[BLOCK_BITS_W-1:0];
        CFG_WAYS:       ways_in_use_q <= cfg_i.data[WAYS_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped geometry
  always_comb begin
    if (int'(set_bits_q) > MAX_SET_BITS) begin
      sb = SET_BITS_W'(MAX_SET_BITS);
    end else begin
      sb = set_bits_q;
    end
    if (ways_in_use_q == '0) begin
      ways_eff = WAYS_W'(1);
    end else if (int'(ways_in_use_q) > MAX_WAYS) begin
      ways_eff = WAYS_W'(MAX_WAYS);
    end else begin
      ways_eff = ways_in_use_q;
    end
  end

  assign set_idx = SET_AW'(addr_sh_q) & ~({SET_AW{1'b1}} << sb);

  // compare and replacement decision
  assign fill        = meta_rdata[META_W-1:WAY_W];
  assign oldest      = meta_rdata[WAY_W-1:0];
  assign line_hit    = (int'(way_q) < int'(fill)) && (tag_rdata == tag_q);
  assign more        = (int'(way_q) + 1 < int'(ways_q)) && (int'(way_q) + 1 < int'(fill));
  assign is_fill     = int'(fill) < int'(ways_q);
  assign victim      = (int'(oldest) >= int'(ways_q)) ? '0 : oldest;
  assign oldest_next = (int'(victim) + 1 >= int'(ways_q)) ? '0 : WAY_W'(victim + 1'b1);
  assign is_modify   = (op_q == OP_MODIFY);
  assign out_free    = !out_valid_q || out_o.ready;
  assign commit      = (state_q == S_CMP) && (line_hit || !more) && out_free;

  always_comb begin
    if (line_hit) begin
      outcome_d = OUT_HIT;
    end else if (is_fill) begin
      outcome_d = OUT_FILL;
    end else begin
      outcome_d = OUT_EVICT;
    end
  end

  // saturating totals
  assign hit_inc = {1'b0, line_hit} + {1'b0, is_modify};
  assign hit_sum = {1'b0, hit_cnt_q} + (COUNT_WIDTH + 1)'(hit_inc);

  always_comb begin
    if (hit_sum > {1'b0, COUNT_MAX}) begin
      hit_cnt_d = COUNT_MAX;
    end else begin
      hit_cnt_d = hit_sum[COUNT_WIDTH-1:0];
    end
    miss_cnt_d  = miss_cnt_q;
    evict_cnt_d = evict_cnt_q;
    if (!line_hit && miss_cnt_q != COUNT_MAX) begin
      miss_cnt_d = miss_cnt_q + 1'b1;
    end
    if (!line_hit && !is_fill && evict_cnt_q != COUNT_MAX) begin
      evict_cnt_d = evict_cnt_q + 1'b1;
    end
  end

  // memory ports
  always_comb begin
    meta_we    = 1'b0;
    meta_waddr = set_q;
    meta_wdata = is_fill ? {FILL_W'(fill + 1'b1), oldest} : {fill, oldest_next};
    meta_re    = 1'b0;
    meta_raddr = set_idx;
    tag_we     = commit && !line_hit;
    tag_waddr  = {set_q, is_fill ? WAY_W'(fill) : victim};
    tag_re     = 1'b0;
    tag_raddr  = {set_idx, WAY_W'(0)};
    case (state_q)
      S_CLEAR: begin
        meta_we    = 1'b1;
        meta_waddr = clr_q;
        meta_wdata = '0;
      end
      S_META: begin
        meta_re = 1'b1;
        tag_re  = 1'b1;
      end
      S_CMP: begin
        meta_we = commit && !line_hit;
        if (!line_hit && more) begin
          tag_re    = 1'b1;
          tag_raddr = {set_q, WAY_W'(way_q + 1'b1)};
        end
      end
      default: ;
    endcase
  end

  sacfs_ram #(
    .WIDTH (META_W),
    .DEPTH (NUM_SETS)
  ) u_meta_ram (
    .clk_i   (clk_i),
    .we_i    (meta_we),
    .waddr_i (meta_waddr),
    .wdata_i (meta_wdata),
    .re_i    (meta_re),
    .raddr_i (meta_raddr),
    .rdata_o (meta_rdata)
  );

  sacfs_ram #(
    .WIDTH (ADDR_W),
    .DEPTH (NUM_LINES)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (tag_we),
    .waddr_i (tag_waddr),
    .wdata_i (tag_q),
    .re_i    (tag_re),
    .raddr_i (tag_raddr),
    .rdata_o (tag_rdata)
  );

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_CLEAR;
      clr_q         <= '0;
      op_q          <= '0;
      addr_sh_q     <= '0;
      tag_q         <= '0;
      set_q         <= '0;
      ways_q        <= '0;
      way_q         <= '0;
      hit_cnt_q     <= '0;
      miss_cnt_q    <= '0;
      evict_cnt_q   <= '0;
      out_valid_q   <= 1'b0;
      outcome_q     <= '0;
      modify_hit_q  <= 1'b0;
      hit_total_q   <= '0;
      miss_total_q  <= '0;
      evict_total_q <= '0;
    end else begin
      if (out_valid_q && out_o.ready && !commit) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == {SET_AW{1'b1}}) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_i.valid) begin
            op_q      <= in_i.op;
            addr_sh_q <= in_i.address >> block_bits_q;
            state_q   <= S_META;
          end
        end
        S_META: begin
          set_q   <= set_idx;
          tag_q   <= addr_sh_q >> sb;
          ways_q  <= ways_eff;
          way_q   <= '0;
          state_q <= S_CMP;
        end
        S_CMP: begin
          if (!line_hit && more) begin
            way_q <= WAY_W'(way_q + 1'b1);
          end else if (out_free) begin
            hit_cnt_q     <= hit_cnt_d;
            miss_cnt_q    <= miss_cnt_d;
            evict_cnt_q   <= evict_cnt_d;
            out_valid_q   <= 1'b1;
            outcome_q     <= outcome_d;
            modify_hit_q  <= is_modify;
            hit_total_q   <= TOTAL_W'(hit_cnt_d);
            miss_total_q  <= TOTAL_W'(miss_cnt_d);
            evict_total_q <= TOTAL_W'(evict_cnt_d);
            state_q       <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_i.ready           = (state_q == S_IDLE);
  assign out_o.valid          = out_valid_q;
  assign out_o.outcome        = outcome_q;
  assign out_o.modify_hit     = modify_hit_q;
  assign out_o.hit_total      = hit_total_q;
  assign out_o.miss_total     = miss_total_q;
  assign out_o.eviction_total = evict_total_q;

endmodule
